>>> hw/rtl/sorted_priority_list_readout_core_macros.svh
// ----------------------------------------------------------------------------
// Sorted priority list readout - assertion macros
// Concurrent check wrappers shared by the RTL; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_LIST_READOUT_CORE_MACROS_SVH
`define SORTED_PRIORITY_LIST_READOUT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// property that must hold on every clock edge out of reset
`define SPLR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define SPLR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPLR_ASSERT(name, clk, rst_n, prop, msg)
`define SPLR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/splr_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority list readout - package
// Capacity, derived widths, result status codes and the sequencer states.
// ----------------------------------------------------------------------------
package splr_pkg;

  // list capacity (2 to 63)
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int unsigned CODE_W = 8;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned CAT_W  = 2;
  localparam int unsigned SEAT_W = 7;
  localparam int unsigned ENTRY_W = CODE_W + PRIO_W;

  // result status
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_LISTED   = 3'd2,
    ST_SUMMARY  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // input command
  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_READOUT = 1'b1
  } command_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_RD_DATA,
    S_SUM,
    S_FIN
  } state_e;

  // one stored entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage

>>> hw/rtl/splr_ram.sv
// ----------------------------------------------------------------------------
// Sorted priority list readout - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module splr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sorted_priority_list_readout_core.sv
// Insert: walks from the tail toward the head, moving each entry of higher priority up a
// slot, then writes the new entry. Readout walks the entries in order, one entry per cycle
// through the single-read-port list RAM; results stall under output backpressure.
// One item at a time; a result waits in the output register while the next item is taken.
// Reset (rst_ni low, async) empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// Sorted priority list readout - top level
// Ordered list in a RAM kept sorted by shift-on-insert; readout walks it in order.
// ----------------------------------------------------------------------------
`include "sorted_priority_list_readout_core_macros.svh"

module sorted_priority_list_readout_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] passenger_code, [15:8] priority_req
  input  logic [0:0]  s_axis_tuser,   // [0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] category, [8:2] seat_number, [15:9] occupied
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast    // last result of the transaction
);

  import splr_pkg::*;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SEAT_W-1:0]   seats_q, seats_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  status_e             fin_st_q, fin_st_d;

  // output register
  logic                o_valid_q, o_valid_d;
  status_e             o_status_q, o_status_d;
  logic [CAT_W-1:0]    o_cat_q, o_cat_d;
  logic [SEAT_W-1:0]   o_seat_q, o_seat_d;
  logic [SEAT_W-1:0]   o_occ_q, o_occ_d;
  logic                o_last_q, o_last_d;

  // RAM port
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;

  logic                in_acc, out_free, list_full, list_empty;
  logic                code_ok, shift_up, at_last, rd_adv;
  command_e            in_cmd;

  splr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared conditions
  assign in_cmd     = command_e'(s_axis_tuser[0]);
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !o_valid_q || m_axis_tready;
  assign list_full  = (cnt_q == CNT_W'(CAPACITY));
  assign list_empty = (cnt_q == '0);
  assign code_ok    = (ram_rdata.code[CODE_W-1:2] == 6'd1);
  assign shift_up   = (ram_rdata.prio > prio_q);
  assign at_last    = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign rd_adv     = !code_ok || out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_INSERT) begin
            if (list_full)       state_d = S_FIN;
            else if (list_empty) state_d = S_INS_PUT;
            else                 state_d = S_INS_CMP;
          end else begin
            if (list_empty) state_d = S_FIN;
            else            state_d = S_RD_DATA;
          end
        end
      end
      S_INS_CMP: begin
        if (shift_up) begin
          if (idx_q == '0) state_d = S_INS_PUT;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_INS_PUT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_RD_DATA: begin
        if (rd_adv && at_last) state_d = S_SUM;
      end
      S_SUM, S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, RAM control and result generation
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_q + IDX_W'(1);
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = idx_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    seats_d       = seats_q;
    code_d        = code_q;
    prio_d        = prio_q;
    fin_st_d      = fin_st_q;
    o_valid_d     = o_valid_q && !m_axis_tready;
    o_status_d    = o_status_q;
    o_cat_d       = o_cat_q;
    o_seat_d      = o_seat_q;
    o_occ_d       = o_occ_q;
    o_last_d      = o_last_q;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          code_d = s_axis_tdata[7:0];
          prio_d = s_axis_tdata[15:8];
          if (in_cmd == CMD_INSERT) begin
            fin_st_d = ST_FULL;
            idx_d    = '0;
            if (!list_full && !list_empty) begin
              // start at the tail and walk toward the head
              ram_re    = 1'b1;
              ram_raddr = IDX_W'(cnt_q - CNT_W'(1));
              idx_d     = IDX_W'(cnt_q - CNT_W'(1));
            end
          end else begin
            fin_st_d  = ST_EMPTY;
            seats_d   = '0;
            idx_d     = '0;
            ram_re    = !list_empty;
            ram_raddr = '0;
          end
        end
      end
      S_INS_CMP: begin
        if (shift_up) begin
          // move the entry up one slot, fetch the next one down
          ram_we = 1'b1;
          if (idx_q != '0) begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - IDX_W'(1);
            idx_d     = idx_q - IDX_W'(1);
          end
        end else if (out_free) begin
          // new entry goes right after this one
          ram_we     = 1'b1;
          ram_wdata  = '{prio: prio_q, code: code_q};
          cnt_d      = cnt_q + CNT_W'(1);
          o_valid_d  = 1'b1;
          o_status_d = ST_INSERTED;
          o_cat_d    = '0;
          o_seat_d   = '0;
          o_occ_d    = '0;
          o_last_d   = 1'b1;
        end
      end
      S_INS_PUT: begin
        if (out_free) begin
          ram_we     = 1'b1;
          ram_waddr  = idx_q;
          ram_wdata  = '{prio: prio_q, code: code_q};
          cnt_d      = cnt_q + CNT_W'(1);
          o_valid_d  = 1'b1;
          o_status_d = ST_INSERTED;
          o_cat_d    = '0;
          o_seat_d   = '0;
          o_occ_d    = '0;
          o_last_d   = 1'b1;
        end
      end
      S_RD_DATA: begin
        if (code_ok && out_free) begin
          seats_d    = seats_q + SEAT_W'(1);
          o_valid_d  = 1'b1;
          o_status_d = ST_LISTED;
          o_cat_d    = ram_rdata.code[CAT_W-1:0];
          o_seat_d   = seats_q + SEAT_W'(1);
          o_occ_d    = '0;
          o_last_d   = 1'b0;
        end
        if (rd_adv && !at_last) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + IDX_W'(1);
          idx_d     = idx_q + IDX_W'(1);
        end
      end
      S_SUM: begin
        if (out_free) begin
          o_valid_d  = 1'b1;
          o_status_d = ST_SUMMARY;
          o_cat_d    = '0;
          o_seat_d   = '0;
          o_occ_d    = seats_q;
          o_last_d   = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          o_valid_d  = 1'b1;
          o_status_d = fin_st_q;
          o_cat_d    = '0;
          o_seat_d   = '0;
          o_occ_d    = '0;
          o_last_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      o_valid_q <= o_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    seats_q    <= seats_d;
    code_q     <= code_d;
    prio_q     <= prio_d;
    fin_st_q   <= fin_st_d;
    o_status_q <= o_status_d;
    o_cat_q    <= o_cat_d;
    o_seat_q   <= o_seat_d;
    o_occ_q    <= o_occ_d;
    o_last_q   <= o_last_d;
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {o_occ_q, o_seat_q, o_cat_q};
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tlast  = o_last_q;

  // checks
  `SPLR_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `SPLR_ASSERT(a_rd_idx, clk_i, rst_ni, (state_q != S_RD_DATA) || (CNT_W'(idx_q) < cnt_q), "readout index past stored entries")
  `SPLR_ASSERT_NEXT(a_busy_after_acc, clk_i, rst_ni, in_acc, state_q != S_IDLE, "sequencer idle after accepted transaction")
  `SPLR_ASSERT(a_listed_not_last, clk_i, rst_ni, !(o_valid_q && o_last_q && (o_status_q == ST_LISTED)), "listed result marked last")

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Sorted priority list readout - testbench
// Drives insert and readout transactions into the core. Each accepted input is
// run through a local model of the sorted list. All the results
// it predicts are queued and then compared field by field with the result
// stream. Both sides of the stream idle at random, in several phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import splr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_MAX  = 10;

  // one predicted result, fields as carried on the result stream
  typedef struct packed {
    status_e    status;
    logic [1:0] category;
    logic [6:0] seat;
    logic [6:0] occupied;
    logic       last;
  } seat_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] passenger_code, [15:8] priority_req
  logic [0:0]  s_axis_tuser = '0;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [1:0] category, [8:2] seat_number, [15:9] occupied
  logic [2:0]  m_axis_tuser;        // [2:0] status
  logic        m_axis_tlast;

  // local copy of the ordered passenger list
  logic [7:0]   list_code [CAPACITY];
  logic [7:0]   list_prio [CAPACITY];
  int unsigned  list_len = 0;
  seat_result_t awaited_seats[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  sorted_priority_list_readout_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // receiver backpressure, changed on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // run the list model for one accepted transaction and queue its results
  function automatic void predict_list_step(command_e cmd, logic [7:0] code,
                                            logic [7:0] prio);
    seat_result_t res;
    int unsigned  slot;
    int unsigned  seats;
    res = '0;
    if (cmd == CMD_INSERT) begin
      res.last = 1'b1;
      if (list_len >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // goes behind every entry of lower or equal priority
        slot = list_len;
        for (int i = 0; i < int'(list_len); i++) begin
          if (list_prio[i] > prio) begin
            slot = i;
            break;
          end
        end
        for (int i = int'(list_len); i > int'(slot); i--) begin
          list_code[i] = list_code[i-1];
          list_prio[i] = list_prio[i-1];
        end
        list_code[slot] = code;
        list_prio[slot] = prio;
        list_len++;
        res.status = ST_INSERTED;
      end
      awaited_seats.push_back(res);
    end else if (list_len == 0) begin
      res.status = ST_EMPTY;
      res.last   = 1'b1;
      awaited_seats.push_back(res);
    end else begin
      seats = 0;
      for (int i = 0; i < int'(list_len); i++) begin
        if (list_code[i] >= 8'd4 && list_code[i] <= 8'd7) begin
          seats++;
          res          = '0;
          res.status   = ST_LISTED;
          res.category = 2'(list_code[i] - 8'd4);
          res.seat     = 7'(seats);
          awaited_seats.push_back(res);
        end
      end
      res          = '0;
      res.status   = ST_SUMMARY;
      res.occupied = 7'(seats);
      res.last     = 1'b1;
      awaited_seats.push_back(res);
    end
  endfunction

  function automatic void note_failure(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("ERROR: %s", what);
  endfunction

  // compare every result transaction with the oldest prediction
  always @(posedge clk_i) begin
    seat_result_t want;
    seat_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status   = status_e'(m_axis_tuser);
      got.category = m_axis_tdata[1:0];
      got.seat     = m_axis_tdata[8:2];
      got.occupied = m_axis_tdata[15:9];
      got.last     = m_axis_tlast;
      if (awaited_seats.size() == 0) begin
        note_failure($sformatf("unexpected result status=%0d cat=%0d seat=%0d occ=%0d last=%0b",
                               got.status, got.category, got.seat, got.occupied, got.last));
      end else begin
        want = awaited_seats.pop_front();
        if (got.status !== want.status || got.category !== want.category ||
            got.seat !== want.seat || got.occupied !== want.occupied ||
            got.last !== want.last) begin
          note_failure($sformatf({"result mismatch: expected status=%0d cat=%0d seat=%0d ",
                                  "occ=%0d last=%0b, got status=%0d cat=%0d seat=%0d ",
                                  "occ=%0d last=%0b"},
                                 want.status, want.category, want.seat, want.occupied,
                                 want.last, got.status, got.category, got.seat,
                                 got.occupied, got.last));
        end
      end
    end
  end

  // hard stop on a hang
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one input transaction; entered and left on a falling edge
  task automatic send_item(input command_e cmd, input logic [7:0] code,
                           input logic [7:0] prio);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, code};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_list_step(cmd, code, prio);
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
  endtask

  // readout with nothing stored
  task automatic test_empty_readout();
    send_item(CMD_READOUT, 8'd5, 8'd0);
  endtask

  // only unrecognised codes stored: summary alone, count zero
  task automatic test_unrecognised_codes();
    send_item(CMD_INSERT, 8'd0, 8'd0);
    send_item(CMD_INSERT, 8'd255, 8'd255);
    send_item(CMD_INSERT, 8'd3, 8'd10);
    send_item(CMD_INSERT, 8'd8, 8'd10);
    send_item(CMD_READOUT, 8'd0, 8'd0);
  endtask

  // ordering at the priority extremes and first-in first-out among ties
  task automatic test_priority_order();
    send_item(CMD_INSERT, 8'd4, 8'd255);
    send_item(CMD_INSERT, 8'd7, 8'd0);
    send_item(CMD_INSERT, 8'd5, 8'd128);
    send_item(CMD_INSERT, 8'd6, 8'd128);
    send_item(CMD_INSERT, 8'd4, 8'd128);
    send_item(CMD_INSERT, 8'd6, 8'd10);
    send_item(CMD_READOUT, 8'd255, 8'd255);
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(9) < 6) return 8'($urandom_range(8, 3));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_prio();
    // coarse values make ties common
    if ($urandom_range(3) == 0) return 8'($urandom_range(3) * 64);
    return 8'($urandom_range(255));
  endfunction

  // random mix; inserts are kept sparse so the list fills over several phases
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned ins_pct;
    for (int unsigned k = 0; k < n_items; k++) begin
      ins_pct = (list_len < CAPACITY) ? 17 : 40;
      if ($urandom_range(99) < ins_pct)
        send_item(CMD_INSERT, pick_code(), pick_prio());
      else
        send_item(CMD_READOUT, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // top the list up to capacity, then drop inserts on a full list
  task automatic test_fill_to_full();
    while (list_len < CAPACITY) begin
      send_item(CMD_INSERT, pick_code(), pick_prio());
      if ($urandom_range(7) == 0) send_item(CMD_READOUT, 8'd0, 8'd0);
    end
    send_item(CMD_INSERT, 8'd7, 8'd0);
    send_item(CMD_INSERT, 8'd4, 8'd255);
    send_item(CMD_READOUT, 8'd0, 8'd0);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(0, 0);
    test_empty_readout();
    test_unrecognised_codes();
    test_priority_order();

    test_random_traffic(90);
    set_idling(49, 0);
    test_random_traffic(90);
    set_idling(0, 49);
    test_random_traffic(90);
    set_idling(6, 6);
    test_fill_to_full();
    test_random_traffic(90);

    s_axis_tvalid <= 1'b0;
    while (awaited_seats.size() != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 8) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_seats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/splr_pkg.sv
hw/rtl/splr_ram.sv
hw/rtl/sorted_priority_list_readout_core.sv
test/testbench.sv
